// ----- rtl/bhd_pkg.sv -----
// shared types, constants and the character class table of the binhex decoder
// no dependencies
package bhd_pkg;

	localparam int MAX_RES = 4;
	localparam int CNT_W = $clog2(MAX_RES + 1);
	localparam int IDX_W = $clog2(MAX_RES);

	localparam logic [7:0] RUN_MARK  = 8'h90;
	localparam logic [7:0] K_WHITE   = 8'hFC;
	localparam logic [7:0] K_COLON   = 8'hFD;
	localparam logic [7:0] K_NEWLINE = 8'hFE;
	localparam logic [7:0] K_INVALID = 8'hFF;

	localparam logic [1:0] ST_DATA    = 2'd0;
	localparam logic [1:0] ST_COLON   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_STRAY   = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] repeat_res;
		logic [1:0] stream_status;
	} bhd_res_t;

	typedef struct packed {
		logic [CNT_W-1:0]          count;
		bhd_res_t [MAX_RES-1:0]    res;
	} bhd_batch_t;

	// sextet value for alphabet characters, otherwise one of the K_ codes
	function automatic logic [7:0] bhd_classify(input logic [7:0] c);
		logic [7:0] k;
		case (c) inside
			8'h0A, 8'h0D:   k = K_NEWLINE;
			8'h09, 8'h20:   k = K_WHITE;
			8'h3A:          k = K_COLON;
			[8'h21:8'h2D]:  k = c - 8'h21;
			[8'h30:8'h36]:  k = c - 8'h23;
			[8'h38:8'h39]:  k = c - 8'h24;
			[8'h40:8'h4E]:  k = c - 8'h2A;
			[8'h50:8'h56]:  k = c - 8'h2B;
			[8'h58:8'h5B]:  k = c - 8'h2C;
			[8'h60:8'h66]:  k = c - 8'h30;
			[8'h68:8'h6D]:  k = c - 8'h31;
			[8'h70:8'h72]:  k = c - 8'h33;
			default:        k = K_INVALID;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/bhd_decode.sv -----
// character decode, sextet grouping and run expansion with the stream state
// depends on bhd_pkg
module bhd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          text_char,
	output bhd_pkg::bhd_batch_t batch
);
	import bhd_pkg::*;

	localparam logic CLS_DATA    = 1'b0;
	localparam logic CLS_NEWLINE = 1'b1;

	typedef struct packed {
		logic [17:0] sextets;
		logic [1:0]  fill;
		logic        prev;
		logic        marker;
		logic [7:0]  last;
		logic        ended;
	} state_t;

	typedef struct packed {
		logic       emit;
		bhd_res_t   res;
		logic       marker;
		logic [7:0] last;
	} push_t;

	function automatic push_t push_byte(input logic marker, input logic [7:0] last,
		input logic [7:0] b);
		push_t p;
		p.emit = 1'b0;
		p.res.data_byte = b;
		p.res.repeat_res = 8'd1;
		p.res.stream_status = ST_DATA;
		p.marker = 1'b0;
		p.last = last;
		if (marker) begin
			if (b == 8'd0) begin
				p.emit = 1'b1;
				p.res.data_byte = RUN_MARK;
				p.last = RUN_MARK;
			end else if (b > 8'd1) begin
				p.emit = 1'b1;
				p.res.data_byte = last;
				p.res.repeat_res = b - 8'd1;
			end
		end else if (b == RUN_MARK) begin
			p.marker = 1'b1;
		end else begin
			p.emit = 1'b1;
			p.last = b;
		end
		return p;
	endfunction

	state_t      st_q;
	state_t      nxt;
	logic [7:0]  k;
	logic [23:0] full;
	logic        do_group;
	logic        term;
	logic [1:0]  status;
	push_t [2:0] p;
	logic [CNT_W-1:0] cnt;

	always_comb begin
		k = bhd_classify(text_char);
		nxt = st_q;
		full = '0;
		do_group = 1'b0;
		term = 1'b0;
		status = ST_DATA;
		if (!st_q.ended) begin
			if (k[7:6] == 2'b00) begin
				nxt.prev = CLS_DATA;
				if (st_q.fill == 2'd3) begin
					full = {st_q.sextets, k[5:0]};
					do_group = 1'b1;
					nxt.sextets = '0;
					nxt.fill = 2'd0;
				end else begin
					nxt.sextets = {st_q.sextets[11:0], k[5:0]};
					nxt.fill = st_q.fill + 2'd1;
				end
			end else if (k == K_NEWLINE) begin
				nxt.prev = CLS_NEWLINE;
			end else if (!(k == K_WHITE && st_q.prev == CLS_NEWLINE)) begin
				term = 1'b1;
				if (k == K_WHITE) begin
					status = ST_STRAY;
				end else if (k == K_COLON) begin
					status = ST_COLON;
				end else begin
					status = ST_INVALID;
				end
				do_group = (st_q.fill != 2'd0);
				case (st_q.fill)
					2'd1:    full = {st_q.sextets[5:0], 18'd0};
					2'd2:    full = {st_q.sextets[11:0], 12'd0};
					2'd3:    full = {st_q.sextets, 6'd0};
					default: full = '0;
				endcase
			end
		end

		p[0] = push_byte(st_q.marker, st_q.last, full[23:16]);
		p[1] = push_byte(p[0].marker, p[0].last, full[15:8]);
		p[2] = push_byte(p[1].marker, p[1].last, full[7:0]);

		batch = '0;
		cnt = '0;
		if (do_group) begin
			nxt.marker = p[2].marker;
			nxt.last = p[2].last;
			for (int i = 0; i < 3; i++) begin
				if (p[i].emit) begin
					batch.res[cnt[IDX_W-1:0]] = p[i].res;
					cnt = cnt + 1'b1;
				end
			end
		end
		if (term) begin
			nxt.sextets = '0;
			nxt.fill = 2'd0;
			nxt.marker = 1'b0;
			nxt.ended = 1'b1;
			batch.res[cnt[IDX_W-1:0]] = '{data_byte: 8'd0, repeat_res: 8'd0,
				stream_status: status};
			cnt = cnt + 1'b1;
		end
		batch.count = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{sextets: '0, fill: 2'd0, prev: CLS_DATA, marker: 1'b0,
				last: 8'd0, ended: 1'b0};
		end else if (step) begin
			st_q <= nxt;
		end
	end

	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ended |=> st_q.ended)
		else $error("stream end flag dropped");

	a_ended_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ended |-> (batch.count == '0))
		else $error("words produced after stream end");

	a_ended_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ended |-> (st_q.fill == 2'd0 && !st_q.marker))
		else $error("group or marker left pending at stream end");

endmodule

// ----- rtl/bhd_rbuf.sv -----
// result buffer holding the words of one character, drained one per cycle while res_stall is low
// depends on bhd_pkg
module bhd_rbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bhd_pkg::bhd_batch_t batch,
	output logic                free,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [7:0]          data_byte,
	output logic [7:0]          repeat_res,
	output logic [1:0]          stream_status,
	output logic                last_of_item
);
	import bhd_pkg::*;

	bhd_res_t [MAX_RES-1:0] res_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   fire;
	bhd_res_t               cur;

	assign cur = res_q[idx_q];
	assign res_valid = (cnt_q != '0);
	assign data_byte = cur.data_byte;
	assign repeat_res = cur.repeat_res;
	assign stream_status = cur.stream_status;
	assign last_of_item = ({1'b0, idx_q} == cnt_q - 1'b1);
	assign fire = res_valid && !res_stall;
	assign free = !res_valid || (fire && last_of_item);

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
			idx_q <= '0;
		end else if (fire) begin
			if (last_of_item) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, idx_q} < cnt_q))
		else $error("read index beyond buffered words");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RES))
		else $error("buffer count too large");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_of_item && !load) |=> !res_valid)
		else $error("buffer not empty after last word");

endmodule

// ----- rtl/binhex_char_decoder_rle.sv -----
// top level of the binhex 4.0 character decoder with run expansion
// depends on bhd_pkg, bhd_decode and bhd_rbuf
//
// Takes one text character per word after the opening colon and gives decoded bytes with
// a repeat count, then one status word when a colon, an invalid character or stray
// whitespace ends the stream. A character is taken every cycle as long as each one yields
// at most one word and res_stall is low; a character that yields more words (up to four)
// holds the input side while the result buffer hands them out one per cycle, barring a
// stall. An accepted character passes the input register and then the result buffer.
// After the end of the stream every character is swallowed until reset.
module binhex_char_decoder_rle (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_char,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] data_byte,
	output logic [7:0] repeat_res,
	output logic [1:0] stream_status,
	output logic       last_of_item
);
	import bhd_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       free;
	logic       load;
	bhd_batch_t batch;

	assign load = valid_s1 && free;
	assign text_stall = valid_s1 && !free;

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			char_s1 <= text_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	bhd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (load),
		.text_char (char_s1),
		.batch     (batch)
	);

	bhd_rbuf u_rbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.batch         (batch),
		.free          (free),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.data_byte     (data_byte),
		.repeat_res    (repeat_res),
		.stream_status (stream_status),
		.last_of_item  (last_of_item)
	);

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load) |=> valid_s1)
		else $error("pending character lost");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && stream_status != ST_DATA) |-> last_of_item)
		else $error("status word not last of its character");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && stream_status != ST_DATA) |-> (repeat_res == 8'd0))
		else $error("status word carries a repeat count");

endmodule
